FILE: design/tpp_pkg.sv
// Package for the tracker pattern packer: beat payload types, cache entry
// layout, opcode and mask constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpp_pkg;

    localparam int CHANNELS_DEFAULT = 64;
    localparam int MAX_BYTES        = 7;

    typedef enum logic [1:0] {
        OP_CELL  = 2'd0,
        OP_ROW   = 2'd1,
        OP_START = 2'd2,
        OP_END   = 2'd3
    } opcode_t;

    localparam logic [1:0] NOTE_NORMAL = 2'd0;
    localparam logic [1:0] NOTE_OFF    = 2'd1;
    localparam logic [7:0] BYTE_OFF    = 8'd255;
    localparam logic [7:0] BYTE_CUT    = 8'd254;

    localparam logic [4:0] CMD_DOUBLE  = 5'd25;
    localparam logic [7:0] PARAM_CAP   = 8'h7F;
    localparam logic [7:0] MARK_MASK   = 8'd128;

    localparam int MB_NOTE      = 0;
    localparam int MB_INST      = 1;
    localparam int MB_VOL       = 2;
    localparam int MB_CMD       = 3;
    localparam int MB_SAME_NOTE = 4;
    localparam int MB_SAME_INST = 5;
    localparam int MB_SAME_VOL  = 6;
    localparam int MB_SAME_CMD  = 7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] channel;
        logic       note_present;
        logic [1:0] note_kind;
        logic [6:0] note_value;
        logic       instrument_present;
        logic [7:0] instrument_index;
        logic       volume_present;
        logic [7:0] volume_value;
        logic       command_present;
        logic [4:0] command_code;
        logic [7:0] command_param;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_length;
        logic [15:0] packed_length;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic       note_on;
        logic [7:0] note;
        logic       inst_on;
        logic [7:0] inst;
        logic       vol_on;
        logic [7:0] vol;
        logic       cmd_on;
        logic [4:0] cmd;
        logic [7:0] param;
        logic [7:0] mask;
    } entry_t;

    typedef struct packed {
        entry_t                          entry;
        logic                            nonempty;
        logic [MAX_BYTES-1:0][7:0]       bytes;
        logic [2:0]                      count;
    } enc_t;

endpackage

`default_nettype wire

FILE: design/tpp_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
// Payload type is set per instance; used with the types of tpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tpp_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/tracker_pattern_packer.sv
// Tracker pattern packer top level: channel cache memory, encode stage and
// byte serializer. Depends on tpp_pkg, tpp_stream_if and tpp_encode.
//
// Usage:
//   cells  : sink of in_item_t beats (cell, end of row, start/end pattern).
//   stream : source of out_item_t beats, one per packed byte, one per row end or
//            one length beat at end of pattern; last marks the final beat of an item.
// Path: an accepted item is registered in the input stage, then its bytes are
//   loaded into the byte serializer once it is free, which presents the first beat.
// Serializer: an item occupies the byte serializer until all the beats it
//   produces are taken (1 to 7 for a cell, 1 for a row or pattern end);
//   items with no beat do not enter it.
//   A new item is taken while the previous one is still draining.
// Reset: rst_n clears the per-channel valid bits and the byte count, so
//   every channel cache reads as empty at once; no clearing pass.
// Stall: while stream.ready is low the current beat holds; an item with beats
//   waits in the encode stage, and cells.ready drops while it waits.
`timescale 1ns / 1ps
`default_nettype none

module tracker_pattern_packer #(
    parameter int CHANNELS = tpp_pkg::CHANNELS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tpp_stream_if.sink       cells,
    tpp_stream_if.source     stream
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    tpp_pkg::entry_t mem [CHANNELS];
    tpp_pkg::entry_t rd_reg;
    tpp_pkg::entry_t byp_data_reg;
    logic            byp_hit_reg;
    logic [CHANNELS-1:0] valid_reg, valid_next;

    tpp_pkg::in_item_t item_reg;
    logic              s1_valid_reg;
    logic [15:0]       count_reg, count_next;

    logic [tpp_pkg::MAX_BYTES-1:0][7:0] buf_bytes_reg;
    logic [2:0]        buf_rem_reg;
    logic              buf_valid_reg;
    logic              buf_len_reg;
    logic [15:0]       buf_length_reg;

    tpp_pkg::entry_t   cache;
    tpp_pkg::enc_t     enc;
    logic [CH_W-1:0]   in_addr, s1_addr;
    logic              in_fire, out_fire, buf_free;
    logic              in_range, cell_emit, has_out, s1_adv, wr_en;
    tpp_pkg::opcode_t  s1_op;

    assign in_addr  = cells.data.channel[CH_W-1:0];
    assign s1_addr  = item_reg.channel[CH_W-1:0];
    assign s1_op    = tpp_pkg::opcode_t'(item_reg.opcode);
    assign in_range = ({1'b0, item_reg.channel} < 7'(CHANNELS));

    assign cache = byp_hit_reg ? byp_data_reg :
                   (valid_reg[s1_addr] ? rd_reg : '0);

    tpp_encode u_encode (
        .item  (item_reg),
        .cache (cache),
        .enc   (enc)
    );

    assign out_fire  = buf_valid_reg && stream.ready;
    assign buf_free  = !buf_valid_reg || (stream.ready && buf_rem_reg == 3'd1);
    assign cell_emit = (s1_op == tpp_pkg::OP_CELL) && in_range && enc.nonempty;
    assign has_out   = (s1_op == tpp_pkg::OP_ROW) || (s1_op == tpp_pkg::OP_END)
                       || cell_emit;
    assign s1_adv    = s1_valid_reg && (!has_out || buf_free);
    assign wr_en     = s1_adv && cell_emit;

    assign cells.ready = !s1_valid_reg || s1_adv;
    assign in_fire     = cells.valid && cells.ready;

    // channel cache memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr] <= enc.entry;
        end
        if (in_fire)
        begin
            rd_reg       <= mem[in_addr];
            byp_data_reg <= enc.entry;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (s1_adv)
        begin
            case (s1_op)
                tpp_pkg::OP_START:
                begin
                    valid_next = '0;
                    count_next = 16'd0;
                end
                tpp_pkg::OP_ROW:
                begin
                    count_next = count_reg + 16'd1;
                end
                tpp_pkg::OP_CELL:
                begin
                    if (cell_emit)
                    begin
                        valid_next[s1_addr] = 1'b1;
                        count_next = count_reg + 16'(enc.count);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= 16'd0;
            s1_valid_reg  <= 1'b0;
            byp_hit_reg   <= 1'b0;
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                byp_hit_reg  <= wr_en && (s1_addr == in_addr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                byp_hit_reg  <= 1'b0;
            end
            if (s1_adv && has_out)
            begin
                buf_valid_reg <= 1'b1;
            end
            else if (out_fire && buf_rem_reg == 3'd1)
            begin
                buf_valid_reg <= 1'b0;
            end
        end
    end

    // input stage and byte serializer payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= cells.data;
        end
        if (s1_adv && has_out)
        begin
            if (cell_emit)
            begin
                buf_bytes_reg  <= enc.bytes;
                buf_rem_reg    <= enc.count;
                buf_len_reg    <= 1'b0;
                buf_length_reg <= 16'd0;
            end
            else
            begin
                buf_bytes_reg  <= '0;
                buf_rem_reg    <= 3'd1;
                buf_len_reg    <= (s1_op == tpp_pkg::OP_END);
                buf_length_reg <= (s1_op == tpp_pkg::OP_END) ? count_reg : 16'd0;
            end
        end
        else if (out_fire)
        begin
            buf_bytes_reg <= buf_bytes_reg >> 8;
            buf_rem_reg   <= buf_rem_reg - 3'd1;
        end
    end

    assign stream.valid              = buf_valid_reg;
    assign stream.data.out_byte      = buf_bytes_reg[0];
    assign stream.data.is_length     = buf_len_reg;
    assign stream.data.packed_length = buf_length_reg;
    assign stream.data.last          = (buf_rem_reg == 3'd1);

endmodule

`default_nettype wire

FILE: design/tpp_encode.sv
// Cell encoder: compares one cell with its channel cache entry, builds the
// new entry and the packed byte list. Depends on tpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpp_encode (
    input  tpp_pkg::in_item_t item,
    input  tpp_pkg::entry_t   cache,
    output tpp_pkg::enc_t     enc
);

    logic       cmd_any;
    logic [7:0] nbyte;
    logic [7:0] flags;
    logic       same_cmd;
    logic [8:0] dbl;
    logic [2:0] k;
    logic [tpp_pkg::MAX_BYTES-1:0][7:0] b;
    tpp_pkg::entry_t nxt;

    always_comb
    begin
        cmd_any = item.command_present || (item.command_param != 8'd0);
        if (item.note_kind == tpp_pkg::NOTE_NORMAL)
        begin
            nbyte = {1'b0, item.note_value};
        end
        else if (item.note_kind == tpp_pkg::NOTE_OFF)
        begin
            nbyte = tpp_pkg::BYTE_OFF;
        end
        else
        begin
            nbyte = tpp_pkg::BYTE_CUT;
        end

        nxt   = cache;
        flags = 8'd0;

        if (item.note_present)
        begin
            if (!cache.note_on || cache.note != nbyte)
            begin
                flags[tpp_pkg::MB_NOTE] = 1'b1;
                nxt.note_on = 1'b1;
                nxt.note    = nbyte;
            end
            else
            begin
                flags[tpp_pkg::MB_SAME_NOTE] = 1'b1;
            end
        end
        if (item.instrument_present)
        begin
            if (!cache.inst_on || cache.inst != item.instrument_index)
            begin
                flags[tpp_pkg::MB_INST] = 1'b1;
                nxt.inst_on = 1'b1;
                nxt.inst    = item.instrument_index;
            end
            else
            begin
                flags[tpp_pkg::MB_SAME_INST] = 1'b1;
            end
        end
        if (item.volume_present)
        begin
            if (!cache.vol_on || cache.vol != item.volume_value)
            begin
                flags[tpp_pkg::MB_VOL] = 1'b1;
                nxt.vol_on = 1'b1;
                nxt.vol    = item.volume_value;
            end
            else
            begin
                flags[tpp_pkg::MB_SAME_VOL] = 1'b1;
            end
        end

        same_cmd = (cache.cmd_on == item.command_present)
                   && (!item.command_present || cache.cmd == item.command_code);
        dbl = {item.command_param, 1'b0};
        if (cmd_any)
        begin
            if (!same_cmd || cache.param != item.command_param)
            begin
                flags[tpp_pkg::MB_CMD] = 1'b1;
                nxt.cmd_on = item.command_present;
                nxt.cmd    = item.command_present ? item.command_code : 5'd0;
                nxt.param  = item.command_param;
                if (item.command_present && item.command_code == tpp_pkg::CMD_DOUBLE
                    && item.command_param < tpp_pkg::PARAM_CAP)
                begin
                    // doubled value stays below 255 here
                    nxt.param = (dbl >= {1'b0, tpp_pkg::PARAM_CAP}) ?
                                tpp_pkg::PARAM_CAP : dbl[7:0];
                end
            end
            else
            begin
                flags[tpp_pkg::MB_SAME_CMD] = 1'b1;
            end
        end
        nxt.mask = flags;

        b = '0;
        k = 3'd0;
        if (flags != cache.mask)
        begin
            b[k] = {2'b00, 6'(7'(item.channel) + 7'd1)} | tpp_pkg::MARK_MASK
                   | {1'b0, 7'(item.channel) + 7'd1};
            k = k + 3'd1;
            b[k] = flags;
            k = k + 3'd1;
        end
        else
        begin
            b[k] = {1'b0, 7'(item.channel) + 7'd1};
            k = k + 3'd1;
        end
        if (flags[tpp_pkg::MB_NOTE])
        begin
            b[k] = nbyte;
            k = k + 3'd1;
        end
        if (flags[tpp_pkg::MB_INST])
        begin
            b[k] = item.instrument_index + 8'd1;
            k = k + 3'd1;
        end
        if (flags[tpp_pkg::MB_VOL])
        begin
            b[k] = item.volume_value;
            k = k + 3'd1;
        end
        if (flags[tpp_pkg::MB_CMD])
        begin
            b[k] = item.command_present ? (8'(item.command_code) + 8'd1) : 8'd0;
            k = k + 3'd1;
            b[k] = item.command_param;
            k = k + 3'd1;
        end

        enc.entry    = nxt;
        enc.nonempty = item.note_present || item.instrument_present
                       || item.volume_present || cmd_any;
        enc.bytes    = b;
        enc.count    = k;
    end

endmodule

`default_nettype wire
